FILE: sv/cctb_pkg.sv
// Shared constants and types of the cycle counter timebase.
`timescale 1ns / 1ps
package cctb_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned TOTAL_W    = 64;
  localparam int unsigned FREQ_W     = 10;
  localparam int unsigned DIVS_W     = 30;
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned FRAC_W     = 10;
  localparam int unsigned TUS_W      = 52;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SEC_STEPS  = 64;
  localparam int unsigned SUB_STEPS  = 10;
  localparam int unsigned US_PER_S   = 1000000;
  localparam int unsigned US_PER_MS  = 1000;
  localparam int unsigned FREQ_RESET = 168;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: sv/cycle_counter_timebase.sv
// Top level of the cycle counter timebase: 64-bit extension and time split.
`timescale 1ns / 1ps
// Usage:
// Each input beat carries one sample of a free-running 32-bit cycle counter.
// A sample below the one before counts as a wrap, and the wrap count forms the
// upper half of a 64-bit cycle total. Each input beat yields exactly one output
// beat with the total, whole seconds (low 32 bits), milliseconds within the
// second, microseconds within the millisecond and a total in microseconds.
// The configuration channel writes the counter clock in MHz; zero acts as one.
// Write it only while no beat is in flight. It is always ready.
// A single shared bit-serial divider does the work: 64 steps for seconds,
// then 10 steps each for milliseconds and microseconds, each pass with a load
// before it and a capture after it, and then a step for the microsecond
// total. One item is worked on at a time, and the input reopens the cycle
// after the result moves to the output register.
// The output sits in its own register, so the next input beat is taken while a
// result waits; a stalled receiver holds the finished next result in the
// block until the output register frees up.
// Reset clears the wrap count and previous sample, sets the clock to 168 MHz
// and empties the output.
module cycle_counter_timebase (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cctb_pkg::SAMPLE_W-1:0]    cycle_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cctb_pkg::TOTAL_W-1:0]     total_cycles_o,
  output logic [cctb_pkg::QUO_W-1:0]       seconds_o,
  output logic [cctb_pkg::FRAC_W-1:0]      milliseconds_o,
  output logic [cctb_pkg::FRAC_W-1:0]      microseconds_o,
  output logic [cctb_pkg::TUS_W-1:0]       total_microseconds_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cctb_pkg::FREQ_W-1:0]      cfg_data_i
);
  import cctb_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD_S  = 4'd1;
  localparam logic [3:0] S_WAIT_S  = 4'd2;
  localparam logic [3:0] S_LOAD_MS = 4'd3;
  localparam logic [3:0] S_WAIT_MS = 4'd4;
  localparam logic [3:0] S_LOAD_US = 4'd5;
  localparam logic [3:0] S_WAIT_US = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [FREQ_W-1:0]  freq_q;
  logic [FREQ_W-1:0]  f_eff;
  logic [DIVS_W-1:0]  per_s;
  logic [DIVS_W-1:0]  per_ms;
  logic               in_beat;
  logic [TOTAL_W-1:0] total;
  div_cmd_t           div_cmd;
  div_sts_t           div_sts;
  logic [TOTAL_W-1:0] div_dividend;
  logic [DIVS_W-1:0]  div_rem_init;
  logic [DIVS_W-1:0]  div_divisor;
  logic [QUO_W-1:0]   div_quo;
  logic [DIVS_W-1:0]  div_rem;
  logic [QUO_W-1:0]   sec_q;
  logic [FRAC_W-1:0]  ms_q;
  logic [FRAC_W-1:0]  us_q;
  logic [TUS_W-1:0]   tus_q;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic [QUO_W-1:0]   out_sec_q;
  logic [FRAC_W-1:0]  out_ms_q;
  logic [FRAC_W-1:0]  out_us_q;
  logic [TUS_W-1:0]   out_tus_q;
  logic               out_free;
  logic               out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == S_OUT) && out_free;

  // A zero clock setting is treated as 1 MHz so no divisor is ever zero.
  assign f_eff  = (freq_q == '0) ? FREQ_W'(1) : freq_q;
  assign per_s  = DIVS_W'(f_eff) * DIVS_W'(US_PER_S);
  assign per_ms = DIVS_W'(f_eff) * DIVS_W'(US_PER_MS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_W'(FREQ_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      freq_q <= cfg_data_i;
    end
  end

  cctb_ext u_ext (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_beat),
    .sample_i (cycle_sample_i),
    .total_o  (total)
  );

  // The seconds pass shifts in all 64 bits of the total. Milliseconds and
  // microseconds are below 1024, so those passes start with the remainder
  // shifted down by ten bits and feed only its low ten bits through.
  always_comb begin
    div_cmd      = '0;
    div_dividend = total;
    div_rem_init = '0;
    div_divisor  = per_s;
    unique case (state_q)
      S_LOAD_S: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = CNT_W'(SEC_STEPS);
      end
      S_LOAD_MS: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = CNT_W'(SUB_STEPS);
        div_dividend  = {div_rem[FRAC_W-1:0], (TOTAL_W-FRAC_W)'(0)};
        div_rem_init  = DIVS_W'(div_rem[DIVS_W-1:FRAC_W]);
        div_divisor   = per_ms;
      end
      S_LOAD_US: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = CNT_W'(SUB_STEPS);
        div_dividend  = {div_rem[FRAC_W-1:0], (TOTAL_W-FRAC_W)'(0)};
        div_rem_init  = DIVS_W'(div_rem[DIVS_W-1:FRAC_W]);
        div_divisor   = DIVS_W'(f_eff);
      end
      default: begin
      end
    endcase
  end

  cctb_sdiv u_sdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i (div_dividend),
    .rem_init_i (div_rem_init),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_beat) state_d = S_LOAD_S;
      S_LOAD_S:  state_d = S_WAIT_S;
      S_WAIT_S:  if (div_sts.done) state_d = S_LOAD_MS;
      S_LOAD_MS: state_d = S_WAIT_MS;
      S_WAIT_MS: if (div_sts.done) state_d = S_LOAD_US;
      S_LOAD_US: state_d = S_WAIT_US;
      S_WAIT_US: if (div_sts.done) state_d = S_MUL;
      S_MUL:     state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The quotient register keeps only the low 32 bits, which truncates seconds.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT_S && div_sts.done) begin
      sec_q <= div_quo;
    end
    if (state_q == S_WAIT_MS && div_sts.done) begin
      ms_q <= div_quo[FRAC_W-1:0];
    end
    if (state_q == S_WAIT_US && div_sts.done) begin
      us_q <= div_quo[FRAC_W-1:0];
    end
    if (state_q == S_MUL) begin
      tus_q <= {(TUS_W-QUO_W)'(0), sec_q} * TUS_W'(US_PER_S)
             + TUS_W'(ms_q) * TUS_W'(US_PER_MS) + TUS_W'(us_q);
    end
    if (out_load) begin
      out_total_q <= total;
      out_sec_q   <= sec_q;
      out_ms_q    <= ms_q;
      out_us_q    <= us_q;
      out_tus_q   <= tus_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign total_cycles_o       = out_total_q;
  assign seconds_o            = out_sec_q;
  assign milliseconds_o       = out_ms_q;
  assign microseconds_o       = out_us_q;
  assign total_microseconds_o = out_tus_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cmd.start |-> !div_sts.busy)
    else $error("divider started while running");
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> ms_q < FRAC_W'(US_PER_MS) && us_q < FRAC_W'(US_PER_MS))
    else $error("millisecond or microsecond part out of range");
  a_beat_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q == S_LOAD_S)
    else $error("input beat did not start a division");

endmodule

FILE: sv/cctb_ext.sv
// Extends the 32-bit counter samples to a 64-bit cycle total by counting wraps.
`timescale 1ns / 1ps
module cctb_ext (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [cctb_pkg::SAMPLE_W-1:0]   sample_i,
  output logic [cctb_pkg::TOTAL_W-1:0]    total_o
);
  import cctb_pkg::*;

  logic [SAMPLE_W-1:0] wrap_q, wrap_d;
  logic [SAMPLE_W-1:0] prev_q;
  logic [TOTAL_W-1:0]  total_q;

  // A sample below the previous one means the counter rolled over.
  assign wrap_d = (sample_i < prev_q) ? wrap_q + SAMPLE_W'(1) : wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= '0;
      prev_q <= '0;
    end else if (load_i) begin
      wrap_q <= wrap_d;
      prev_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      total_q <= {wrap_d, sample_i};
    end
  end

  assign total_o = total_q;

  a_prev_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> prev_q == $past(sample_i))
    else $error("previous sample not taken on load");
  a_wrap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_i |=> $stable(wrap_q))
    else $error("wrap count moved without a load");

endmodule

FILE: sv/cctb_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module cctb_sdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cctb_pkg::div_cmd_t            cmd_i,
  input  logic [cctb_pkg::TOTAL_W-1:0]  dividend_i,
  input  logic [cctb_pkg::DIVS_W-1:0]   rem_init_i,
  input  logic [cctb_pkg::DIVS_W-1:0]   divisor_i,
  output cctb_pkg::div_sts_t            sts_o,
  output logic [cctb_pkg::QUO_W-1:0]    quotient_o,
  output logic [cctb_pkg::DIVS_W-1:0]   rem_o
);
  import cctb_pkg::*;

  logic [TOTAL_W-1:0] dvd_q, dvd_d;
  logic [DIVS_W-1:0]  rem_q, rem_d;
  logic [DIVS_W-1:0]  dsr_q, dsr_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DIVS_W:0]    trial;
  logic [DIVS_W:0]    diff;
  logic               ge;

  // The partial remainder stays below the divisor, so one extra bit holds the trial.
  assign trial = {rem_q, dvd_q[TOTAL_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      dvd_d  = dividend_i;
      rem_d  = rem_init_i;
      dsr_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = cmd_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TOTAL_W-2:0], 1'b0};
      rem_d = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;
  assign rem_o      = rem_q;

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0)
    else $error("step count left over while idle");
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished run");

endmodule

FILE: tb/sv/cycle_counter_timebase_test.sv
// Self-checking testbench of the cycle counter timebase with a built-in time split predictor.
`timescale 1ns / 1ps
module cycle_counter_timebase_test;
  import cctb_pkg::*;

  // The whole run must finish well inside this many clock cycles. A correct
  // run sends about 950 beats, with stalls.
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_BEATS  = 116;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned DRAIN_CYCLES = 120;

  // One result beat of the block, field by field.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [QUO_W-1:0]   secs;
    logic [FRAC_W-1:0]  msec;
    logic [FRAC_W-1:0]  usec;
    logic [TUS_W-1:0]   total_us;
  } timebase_t;

  // A row of the directed part either sends one sample or sets the clock.
  typedef enum logic [0:0] {ROW_SAMPLE, ROW_FREQ} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [SAMPLE_W-1:0] value;
    logic                typed;
    timebase_t           want;
  } plan_row_t;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_e;

  // Every input of the block holds a known value from time zero.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   cycle_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [TOTAL_W-1:0]    total_cycles_o;
  logic [QUO_W-1:0]      seconds_o;
  logic [FRAC_W-1:0]     milliseconds_o;
  logic [FRAC_W-1:0]     microseconds_o;
  logic [TUS_W-1:0]      total_microseconds_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [FREQ_W-1:0]     cfg_data_i     = '0;

  // Mirror of the block's state, kept up to date as beats are accepted and the clock is written.
  logic [FREQ_W-1:0]     freq_now    = FREQ_W'(FREQ_RESET);
  logic [SAMPLE_W-1:0]   wrap_cnt    = '0;
  logic [SAMPLE_W-1:0]   last_sample = '0;

  // Time splits that are still owed by the block, oldest first.
  timebase_t             pending_splits[$];
  plan_row_t             plan[$];
  timebase_t             oldest;

  int unsigned           mismatches   = 0;
  int unsigned           results_seen = 0;
  int unsigned           burst_left   = 0;
  int unsigned           cycle_count  = 0;

  // Receiver state: a long hold-off once, otherwise segments of stall modes.
  int unsigned           hold_left = 0;
  logic                  hold_done = 1'b0;
  int unsigned           seg_left  = 0;
  rx_mode_e              seg_mode  = RX_OPEN;

  cycle_counter_timebase u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cycle_sample_i      (cycle_sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .total_cycles_o      (total_cycles_o),
    .seconds_o           (seconds_o),
    .milliseconds_o      (milliseconds_o),
    .microseconds_o      (microseconds_o),
    .total_microseconds_o(total_microseconds_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Extends one sample to the 64-bit cycle total and splits it by the clock.
  // A sample below the previous one counts as a wrap; an equal one does not.
  // A clock setting of zero divides as if it were one.
  function automatic timebase_t split_sample(input logic [SAMPLE_W-1:0] sample);
    timebase_t   split;
    logic [63:0] freq, per_s, per_ms, rem, whole_s, ms, us, secs32;
    freq   = (freq_now == '0) ? 64'd1 : {{(64 - FREQ_W){1'b0}}, freq_now};
    per_s  = freq * 64'd1000000;
    per_ms = freq * 64'd1000;
    if (sample < last_sample) begin
      wrap_cnt = wrap_cnt + SAMPLE_W'(1);
    end
    last_sample = sample;
    split.total = {wrap_cnt, sample};
    whole_s     = split.total / per_s;
    rem         = split.total % per_s;
    ms          = rem / per_ms;
    us          = (rem % per_ms) / freq;
    // Seconds keep only their low 32 bits, and the microsecond total is
    // formed from the truncated value.
    secs32         = {32'd0, whole_s[31:0]};
    split.secs     = whole_s[QUO_W-1:0];
    split.msec     = ms[FRAC_W-1:0];
    split.usec     = us[FRAC_W-1:0];
    split.total_us = TUS_W'(secs32 * 64'd1000000 + ms * 64'd1000 + us);
    return split;
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [SAMPLE_W-1:0] value,
                                  input logic typed = 1'b0, input timebase_t want = '0);
    plan_row_t row;
    row.kind  = kind;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s at result %0d: got 0x%0h, want 0x%0h", what, results_seen, got,
             want);
    mismatches++;
  endtask

  // Offers one sample beat. The sender works in bursts; between bursts it may
  // drop valid for a random gap, and a gap of zero keeps the stream unbroken.
  // A typed expectation, where given, replaces the predicted one.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic typed = 1'b0,
                             input timebase_t want = '0);
    timebase_t   predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    cycle_sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = split_sample(sample);
    pending_splits.push_back(typed ? want : predicted);
  endtask

  // Sets the clock only while the block is idle, that is once every owed
  // result has been taken. The wrap count and last sample carry over.
  task automatic write_freq(input logic [FREQ_W-1:0] freq);
    in_valid_i <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= freq;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    freq_now = freq;
  endtask

  // The receiver. Once, after a few hundred results, it holds off for a long
  // stretch while the sender keeps offering beats, so the block fills its
  // output register and its internal result and then stalls the input.
  // Otherwise it runs segments of random length that are always ready,
  // ready half the time, or ready only a quarter of the time.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (seg_left == 0) begin
      seg_mode    <= rx_mode_e'($urandom_range(0, 2));
      seg_left    <= $urandom_range(8, 200);
      out_ready_i <= 1'b1;
    end else begin
      seg_left <= seg_left - 1;
      case (seg_mode)
        RX_OPEN: begin
          out_ready_i <= 1'b1;
        end
        RX_COIN: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Each result beat is held against the oldest owed split, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_splits.size() == 0) begin
        report_mismatch("result with nothing owed", total_cycles_o, 64'd0);
      end else begin
        oldest = pending_splits.pop_front();
        if (total_cycles_o !== oldest.total) begin
          report_mismatch("total_cycles", total_cycles_o, oldest.total);
        end
        if (seconds_o !== oldest.secs) begin
          report_mismatch("seconds", 64'(seconds_o), 64'(oldest.secs));
        end
        if (milliseconds_o !== oldest.msec) begin
          report_mismatch("milliseconds", 64'(milliseconds_o), 64'(oldest.msec));
        end
        if (microseconds_o !== oldest.usec) begin
          report_mismatch("microseconds", 64'(microseconds_o), 64'(oldest.usec));
        end
        if (total_microseconds_o !== oldest.total_us) begin
          report_mismatch("total_microseconds", 64'(total_microseconds_o),
                          64'(oldest.total_us));
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : main
    logic [SAMPLE_W-1:0] cursor;
    logic [FREQ_W-1:0]   freq;
    int unsigned         pick;

    // Directed part. After reset the clock is 168 MHz. With a clock of one
    // (or zero, which acts as one) and no wrap yet, every field reads straight
    // off the sample.
    add_row(ROW_SAMPLE, 32'd0, 1'b1, '{64'd0, 32'd0, 10'd0, 10'd0, 52'd0});
    add_row(ROW_SAMPLE, 32'd0, 1'b1, '{64'd0, 32'd0, 10'd0, 10'd0, 52'd0});
    add_row(ROW_SAMPLE, 32'd168000, 1'b1, '{64'd168000, 32'd0, 10'd1, 10'd0, 52'd1000});
    add_row(ROW_SAMPLE, 32'd168000000, 1'b1,
            '{64'd168000000, 32'd1, 10'd0, 10'd0, 52'd1000000});
    add_row(ROW_FREQ, 32'd1);
    add_row(ROW_SAMPLE, 32'd1000000000, 1'b1,
            '{64'd1000000000, 32'd1000, 10'd0, 10'd0, 52'd1000000000});
    add_row(ROW_SAMPLE, 32'd1000999999, 1'b1,
            '{64'd1000999999, 32'd1000, 10'd999, 10'd999, 52'd1000999999});
    add_row(ROW_FREQ, 32'd0);
    add_row(ROW_SAMPLE, 32'd1001000001, 1'b1,
            '{64'd1001000001, 32'd1001, 10'd0, 10'd1, 52'd1001000001});
    add_row(ROW_SAMPLE, 32'd1001000001, 1'b1,
            '{64'd1001000001, 32'd1001, 10'd0, 10'd1, 52'd1001000001});
    // Largest clock setting, the top sample, a wrap to zero and a repeat.
    add_row(ROW_FREQ, 32'd1023);
    add_row(ROW_SAMPLE, 32'hFFFF_FFFF);
    add_row(ROW_SAMPLE, 32'h0000_0000);
    add_row(ROW_SAMPLE, 32'h0000_0000);
    add_row(ROW_FREQ, 32'd1000);
    add_row(ROW_SAMPLE, 32'h7FFF_FFFF);
    add_row(ROW_SAMPLE, 32'h8000_0000);
    add_row(ROW_SAMPLE, 32'hFFFF_FFFE);
    add_row(ROW_SAMPLE, 32'h0000_0001);
    add_row(ROW_FREQ, FREQ_RESET);
    add_row(ROW_SAMPLE, 32'h1234_5678);
    add_row(ROW_SAMPLE, 32'hFFFF_FFFF);
    add_row(ROW_SAMPLE, 32'h0000_0000);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_FREQ) begin
        write_freq(plan[i].value[FREQ_W-1:0]);
      end else begin
        send_sample(plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    // Random part: each phase sets a clock, then streams samples. Most beats
    // follow a counter that runs forward in steps of varied size, so wraps
    // come naturally and the wrap count keeps climbing; the rest are random
    // jumps, counters that step back and repeated samples.
    cursor = 32'h0000_0000;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       freq = FREQ_W'($urandom_range(0, 1023));
        1:       freq = 10'd1;
        2:       freq = 10'd1023;
        3:       freq = 10'd0;
        4:       freq = FREQ_W'($urandom_range(1, 50));
        5:       freq = 10'd1000;
        6:       freq = FREQ_W'($urandom_range(100, 999));
        default: freq = FREQ_W'($urandom_range(0, 1023));
      endcase
      write_freq(freq);
      for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          cursor = cursor + $urandom_range(0, 5000);
        end else if (pick < 80) begin
          cursor = cursor + $urandom();
        end else if (pick < 88) begin
          cursor = $urandom();
        end else if (pick < 95) begin
          cursor = cursor - $urandom_range(1, 1000);
        end
        send_sample(cursor);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cctb_pkg.sv
sv/cctb_ext.sv
sv/cctb_sdiv.sv
sv/cycle_counter_timebase.sv
tb/sv/cycle_counter_timebase_test.sv
